@@ sv/rc_pkg.sv @@
// shared types, constants and helpers for the rice codec
`timescale 1ns / 1ps

package rc_pkg;

  localparam int VALUE_BITS_DEF = 10;
  localparam int CHUNK_BITS_DEF = 32;

  localparam int K_BITS        = 4;
  localparam int TAIL_BITS     = 9;   // terminating one plus up to eight remainder bits
  localparam int QCOUNT_BITS   = 11;
  localparam int ACC_BITS      = 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 4;

  localparam logic [K_BITS-1:0]      K_MAX      = 4'd8;
  localparam logic [QCOUNT_BITS-1:0] QCOUNT_MAX = 11'd2047;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RICE_K    = 1'b1;

  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } rc_state_t;

  // encoder control from the sequencer
  typedef struct packed {
    logic start;
    logic advance;
  } enc_ctl_t;

  // decoder control and status
  typedef struct packed {
    logic step;
    logic code_bit;
  } dec_ctl_t;

  typedef struct packed {
    logic emit;
    logic overflow;
  } dec_stat_t;

  // k values above eight behave as eight
  function automatic logic [K_BITS-1:0] eff_k(input logic [K_BITS-1:0] k);
    eff_k = (k > K_MAX) ? K_MAX : k;
  endfunction

endpackage

@@ sv/rc_enc.sv @@
// encoder chunk generator: one chunk per advance through a shared shifter
`timescale 1ns / 1ps

module rc_enc
  import rc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int CHUNK_BITS = CHUNK_BITS_DEF
) (
  input  logic                            clk,
  input  enc_ctl_t                        ctl,
  input  logic [VALUE_BITS-1:0]           value,
  input  logic [K_BITS-1:0]               k,
  output logic [CHUNK_BITS-1:0]           chunk,
  output logic [$clog2(CHUNK_BITS+1)-1:0] bits,
  output logic                            last
);

  localparam int CW = $clog2(CHUNK_BITS + 1);
  localparam int NW = (VALUE_BITS + 1 > CW) ? VALUE_BITS + 1 : CW;
  localparam int EW = (VALUE_BITS > TAIL_BITS) ? VALUE_BITS : TAIL_BITS;
  localparam int XW = CHUNK_BITS + TAIL_BITS;

  logic [VALUE_BITS-1:0] zeros_r, zeros_nxt;
  logic [TAIL_BITS-1:0]  tail_r, tail_nxt;
  logic [K_BITS-1:0]     tlen_r, tlen_nxt;

  logic [EW-1:0]          val_ext;
  logic [EW-1:0]          one_k;
  logic [TAIL_BITS:0]     len_bit;
  logic [TAIL_BITS-1:0]   tail_m;
  logic [NW-1:0]          n_tot;
  logic [NW-1:0]          chunk_n;
  logic [NW-1:0]          zeros_w;
  logic [XW-1:0]          shifted;

  always_comb begin
    val_ext = EW'(value);
    one_k   = EW'(1) << k;
    len_bit = (TAIL_BITS + 1)'(1) << tlen_r;
    tail_m  = tail_r & TAIL_BITS'(len_bit - (TAIL_BITS + 1)'(1));
    zeros_w = NW'(zeros_r);
    n_tot   = zeros_w + NW'(tlen_r);
    chunk_n = NW'(CHUNK_BITS);

    zeros_nxt = zeros_r;
    tail_nxt  = tail_r;
    tlen_nxt  = tlen_r;
    shifted   = '0;
    last      = 1'b0;
    bits      = CW'(CHUNK_BITS);

    if (n_tot <= chunk_n) begin
      // everything left fits: tail left aligned after the zeros
      shifted = XW'(tail_m) << CW'(chunk_n - n_tot);
      bits    = CW'(n_tot);
      last    = 1'b1;
    end else if (zeros_w >= chunk_n) begin
      // full chunk of unary zeros
      shifted   = '0;
      zeros_nxt = zeros_r - VALUE_BITS'(CHUNK_BITS);
    end else begin
      // zeros then the top of the tail, rest goes to the next chunk
      shifted   = XW'(tail_m) >> (n_tot - chunk_n);
      zeros_nxt = '0;
      tlen_nxt  = K_BITS'(n_tot - chunk_n);
    end
    chunk = shifted[CHUNK_BITS-1:0];

    if (ctl.start) begin
      zeros_nxt = value >> k;
      tail_nxt  = TAIL_BITS'(one_k | (val_ext & (one_k - EW'(1))));
      tlen_nxt  = k + K_BITS'(1);
    end else if (!ctl.advance) begin
      zeros_nxt = zeros_r;
      tail_nxt  = tail_r;
      tlen_nxt  = tlen_r;
    end
  end

  always_ff @(posedge clk) begin
    zeros_r <= zeros_nxt;
    tail_r  <= tail_nxt;
    tlen_r  <= tlen_nxt;
  end

endmodule

@@ sv/rc_dec.sv @@
// decoder: unary zero counter and remainder gatherer, one code bit per step
`timescale 1ns / 1ps

module rc_dec
  import rc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dec_ctl_t              ctl,
  input  logic [K_BITS-1:0]     k,
  output dec_stat_t             stat,
  output logic [VALUE_BITS-1:0] value
);

  localparam int SW = QCOUNT_BITS + 8;
  localparam logic [SW-1:0] MAXV = SW'((SW'(1) << VALUE_BITS) - SW'(1));

  logic                   in_rem_r, in_rem_nxt;
  logic [QCOUNT_BITS-1:0] qc_r, qc_nxt;
  logic [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic [K_BITS-1:0]      left_r, left_nxt;

  logic [ACC_BITS-1:0] acc_shift;
  logic [ACC_BITS-1:0] acc_sel;
  logic [K_BITS-1:0]   left_dec;
  logic [SW-1:0]       sum;
  logic                emit;

  always_comb begin
    acc_shift = {acc_r[ACC_BITS-2:0], ctl.code_bit};
    left_dec  = (left_r == '0) ? '0 : left_r - K_BITS'(1);
    acc_sel   = in_rem_r ? acc_shift : acc_r;
    sum       = (SW'(qc_r) << k) + SW'(acc_sel);

    in_rem_nxt = in_rem_r;
    qc_nxt     = qc_r;
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    emit       = 1'b0;

    if (ctl.step) begin
      if (!in_rem_r) begin
        if (!ctl.code_bit) begin
          if (qc_r != QCOUNT_MAX) qc_nxt = qc_r + QCOUNT_BITS'(1);
        end else if (k == '0) begin
          emit = 1'b1;
        end else begin
          in_rem_nxt = 1'b1;
          acc_nxt    = '0;
          left_nxt   = k;
        end
      end else begin
        acc_nxt  = acc_shift;
        left_nxt = left_dec;
        if (left_dec == '0) emit = 1'b1;
      end
    end

    if (emit) begin
      in_rem_nxt = 1'b0;
      qc_nxt     = '0;
      acc_nxt    = '0;
      left_nxt   = '0;
    end

    stat.emit     = emit;
    stat.overflow = (qc_r == QCOUNT_MAX) || (sum > MAXV);
    value         = stat.overflow ? MAXV[VALUE_BITS-1:0] : sum[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rem_r <= 1'b0;
      qc_r     <= '0;
      acc_r    <= '0;
      left_r   <= '0;
    end else begin
      in_rem_r <= in_rem_nxt;
      qc_r     <= qc_nxt;
      acc_r    <= acc_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

@@ sv/rice_codec_unit.sv @@
// rice codec top level: config registers, sequencer, encoder, decoder, output register
//
//   channel | ports                                   | direction | transfer
//   --------+-----------------------------------------+-----------+---------------------
//   in      | in_valid in_stall in_value in_code_bit  | sink      | valid && !stall
//   out     | out_valid out_stall out_code_chunk ...  | source    | valid && !stall
//   cfg     | cfg_we cfg_index cfg_data               | sink      | cfg_we
//
// decode: one code bit per cycle while the input is not stalled, the result (if any) lands
// in the output register at the same edge the bit transfers
// encode: the value is loaded first, then the chunks leave through the shared chunk
// shifter while the output can take them, ceil((q + 1 + k) / CHUNK_BITS) chunks per value
// reset is synchronous, active low: direction encode, k two, decode state cleared
// a stalled output holds the chunk sequencer and blocks new input transfers
`timescale 1ns / 1ps

module rice_codec_unit
  import rc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int CHUNK_BITS = CHUNK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [VALUE_BITS-1:0]           in_value,
  input  logic                            in_code_bit,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [CHUNK_BITS-1:0]           out_code_chunk,
  output logic [$clog2(CHUNK_BITS+1)-1:0] out_chunk_bits,
  output logic                            out_last,
  output logic [VALUE_BITS-1:0]           out_decoded_value,
  output logic                            out_overflow,
  // configuration
  input  logic                            cfg_we,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int CW = $clog2(CHUNK_BITS + 1);

  // configuration registers
  logic              direction_r;
  logic [K_BITS-1:0] rice_k_r;
  logic [K_BITS-1:0] k_eff;

  // sequencer
  rc_state_t state_r, state_nxt;
  logic      in_xfer;
  logic      out_free;
  enc_ctl_t  enc_ctl;
  dec_ctl_t  dec_ctl;
  dec_stat_t dec_stat;

  // datapath results
  logic [CHUNK_BITS-1:0] enc_chunk;
  logic [CW-1:0]         enc_bits;
  logic                  enc_last;
  logic [VALUE_BITS-1:0] dec_value;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [CHUNK_BITS-1:0] out_chunk_r, out_chunk_nxt;
  logic [CW-1:0]         out_bits_r, out_bits_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [VALUE_BITS-1:0] out_dval_r, out_dval_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  assign k_eff = eff_k(rice_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      rice_k_r    <= K_BITS'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction_r <= cfg_data[0];
        CFG_RICE_K:    rice_k_r    <= cfg_data[K_BITS-1:0];
        default: ;
      endcase
    end
  end

  // output slot is free when empty or draining this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_nxt        = state_r;
    enc_ctl.start    = 1'b0;
    enc_ctl.advance  = 1'b0;
    dec_ctl.step     = 1'b0;
    dec_ctl.code_bit = in_code_bit;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (direction_r == DIR_ENCODE) begin
            enc_ctl.start = 1'b1;
            state_nxt     = ST_ENC;
          end else begin
            dec_ctl.step = 1'b1;
          end
        end
      end
      ST_ENC: begin
        // one chunk per cycle while the output slot can take it
        if (out_free) begin
          enc_ctl.advance = 1'b1;
          if (enc_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  rc_enc #(
    .VALUE_BITS (VALUE_BITS),
    .CHUNK_BITS (CHUNK_BITS)
  ) u_enc (
    .clk   (clk),
    .ctl   (enc_ctl),
    .value (in_value),
    .k     (k_eff),
    .chunk (enc_chunk),
    .bits  (enc_bits),
    .last  (enc_last)
  );

  rc_dec #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dec_ctl),
    .k     (k_eff),
    .stat  (dec_stat),
    .value (dec_value)
  );

  // output register load: encoder chunk or decoded value
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_chunk_nxt = out_chunk_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    out_dval_nxt  = out_dval_r;
    out_ovf_nxt   = out_ovf_r;
    priority if (enc_ctl.advance) begin
      out_valid_nxt = 1'b1;
      out_chunk_nxt = enc_chunk;
      out_bits_nxt  = enc_bits;
      out_last_nxt  = enc_last;
      out_dval_nxt  = '0;
      out_ovf_nxt   = 1'b0;
    end else if (dec_stat.emit) begin
      out_valid_nxt = 1'b1;
      out_chunk_nxt = '0;
      out_bits_nxt  = '0;
      out_last_nxt  = 1'b1;
      out_dval_nxt  = dec_value;
      out_ovf_nxt   = dec_stat.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    out_chunk_r <= out_chunk_nxt;
    out_bits_r  <= out_bits_nxt;
    out_last_r  <= out_last_nxt;
    out_dval_r  <= out_dval_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_code_chunk    = out_chunk_r;
  assign out_chunk_bits    = out_bits_r;
  assign out_last          = out_last_r;
  assign out_decoded_value = out_dval_r;
  assign out_overflow      = out_ovf_r;

  // no input transfer while chunks are still being produced
  a_no_input_in_enc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENC) |-> in_stall)
    else $error("input transfer during encode");

  // an encode transfer always starts the chunk sequence
  a_enc_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && direction_r == DIR_ENCODE) |=> (state_r == ST_ENC))
    else $error("encode transfer did not start chunk sequence");

  // decoder only emits in decode direction
  a_dec_dir: assert property (@(posedge clk) disable iff (!rst_n)
    dec_stat.emit |-> (direction_r == DIR_DECODE))
    else $error("decode result in encode direction");

  // encoded chunks always carry bits
  a_enc_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && direction_r == DIR_ENCODE) |-> (out_chunk_bits != '0))
    else $error("empty encoded chunk");

endmodule
